// ===== hdl/assert_macros.svh =====
// assertion macros shared by the sprite quad corner generator
// include guarded, clock and reset names follow the project ports
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define SQV_CHECK(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// condition that must be followed by a result in the next cycle
`define SQV_CHECK_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/sqv_pkg.sv =====
// shared types, constants and helpers for the sprite quad corner generator
// no dependencies; used by every module in hdl
package sqv_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_FRAC   = 30;
   localparam int CORDIC_ROUNDS = 30;
   localparam int ITER_W        = $clog2(CORDIC_ROUNDS);
   localparam int ANGLE_W       = 21;
   localparam int ANG_SHIFT_W   = ANGLE_W + CORDIC_FRAC - FRAC_BITS;
   localparam int ANG_W         = ((ANG_SHIFT_W > 33) ? ANG_SHIFT_W : 33) + 2;
   localparam int CRD_W         = 34;
   localparam int MUL_W         = 32 + CRD_W;
   localparam int WIDE_W        = MUL_W + 2;

   localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(36'sd3373259426);
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(36'sd1686629713);
   localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = ANG_W'(36'sd6746518852);
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = CRD_W'(36'sd652032874);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int DIV_STEPS = 32;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_LEFT   = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_TOP    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_RIGHT  = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_BOTTOM = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_PIVOT_X     = CSR_ADDR_W'(4);
   localparam logic [CSR_ADDR_W-1:0] CSR_PIVOT_Y     = CSR_ADDR_W'(5);
   localparam logic [CSR_ADDR_W-1:0] CSR_UPP         = CSR_ADDR_W'(6);
   localparam logic [CSR_ADDR_W-1:0] CSR_TEX_SIZE    = CSR_ADDR_W'(7);

   localparam logic [31:0] ONE_Q        = 32'd1 << FRAC_BITS;
   localparam logic [31:0] HALF_Q       = 32'd1 << (FRAC_BITS - 1);
   localparam logic [23:0] UPP_ONE      = 24'd1 << FRAC_BITS;
   localparam logic [31:0] TEX_SIZE_RST = 32'h0001_0001;
   localparam logic [16:0] TEX_MAX      = 17'h1_FFFF;

   localparam int REQ_TDATA_W = 264;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 104;

   typedef enum logic [1:0] {
      FUNC_POS  = 2'd0,
      FUNC_ROT  = 2'd1,
      FUNC_DEST = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_SCALE,
      BE_POST,
      BE_REDUCE,
      BE_CORDIC,
      BE_ROT,
      BE_ROTPOST,
      BE_DONE
   } be_state_type;

   typedef struct packed {
      func_type    func;
      logic        rot;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [23:0] scale_x;
      logic [23:0] scale_y;
      logic [20:0] angle;
      logic [31:0] dest_left;
      logic [31:0] dest_top;
      logic [31:0] dest_right;
      logic [31:0] dest_bottom;
   } item_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] loc_xa;
      logic [31:0] loc_xb;
      logic [31:0] loc_ya;
      logic [31:0] loc_yb;
      logic [16:0] tex_ua;
      logic [16:0] tex_ub;
      logic [16:0] tex_va;
      logic [16:0] tex_vb;
   } setup_type;

   typedef struct packed {
      logic [3:0][31:0] vx;
      logic [3:0][31:0] vy;
      logic [16:0]      ua;
      logic [16:0]      ub;
      logic [16:0]      va;
      logic [16:0]      vb;
   } quad_type;

   function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic [31:0] r;
      if ((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31])) begin
         r = v[31:0];
      end else if (v[WIDE_W-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0: r = ANG_W'(32'sd843314857);
         5'd1: r = ANG_W'(32'sd497837829);
         5'd2: r = ANG_W'(32'sd263043837);
         5'd3: r = ANG_W'(32'sd133525159);
         5'd4: r = ANG_W'(32'sd67021687);
         5'd5: r = ANG_W'(32'sd33543516);
         5'd6: r = ANG_W'(32'sd16775851);
         5'd7: r = ANG_W'(32'sd8388437);
         5'd8: r = ANG_W'(32'sd4194283);
         5'd9: r = ANG_W'(32'sd2097149);
         default: r = ANG_W'(32'sd1048576) >>> (i - ITER_W'(10));
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/sqv_setup.sv =====
// configuration registers and the derived per-config values
// texture coordinate dividers and local corner products; uses sqv_pkg
module sqv_setup
   import sqv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output setup_type             setup
);
`include "assert_macros.svh"

   logic [31:0] rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;
   logic [31:0] pivot_x_ff, pivot_y_ff, tex_size_ff;
   logic [23:0] upp_ff;
   logic [31:0] rect_left_in, rect_top_in, rect_right_in, rect_bottom_in;
   logic [31:0] pivot_x_in, pivot_y_in, tex_size_in;
   logic [23:0] upp_in;

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;

   logic [31:0] num_ff [4];
   logic [31:0] num_in [4];
   logic [15:0] rem_ff [4];
   logic [15:0] rem_in [4];
   logic [31:0] quo_ff [4];
   logic [31:0] quo_in [4];

   logic signed [57:0] mprod_ff, mprod_in;
   logic [1:0]         midx_ff, midx_in;
   logic               mvld_ff, mvld_in;
   logic [31:0]        loc_ff [4];
   logic [31:0]        loc_in [4];

   logic [31:0]        edge_v [4];
   logic [15:0]        div_v  [4];
   logic [16:0]        shl;
   logic signed [32:0] term;
   logic [1:0]         tidx;

   always_comb begin
      rect_left_in   = rect_left_ff;
      rect_top_in    = rect_top_ff;
      rect_right_in  = rect_right_ff;
      rect_bottom_in = rect_bottom_ff;
      pivot_x_in     = pivot_x_ff;
      pivot_y_in     = pivot_y_ff;
      upp_in         = upp_ff;
      tex_size_in    = tex_size_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_RECT_LEFT:   rect_left_in   = csr_wdata;
            CSR_RECT_TOP:    rect_top_in    = csr_wdata;
            CSR_RECT_RIGHT:  rect_right_in  = csr_wdata;
            CSR_RECT_BOTTOM: rect_bottom_in = csr_wdata;
            CSR_PIVOT_X:     pivot_x_in     = csr_wdata;
            CSR_PIVOT_Y:     pivot_y_in     = csr_wdata;
            CSR_UPP:         upp_in         = csr_wdata[23:0];
            CSR_TEX_SIZE:    tex_size_in    = csr_wdata;
            default:         ;
         endcase
      end
   end

   // lanes: left/right over width, top/bottom over height; zero size acts as one
   always_comb begin
      edge_v[0] = rect_left_ff;
      edge_v[1] = rect_right_ff;
      edge_v[2] = rect_top_ff;
      edge_v[3] = rect_bottom_ff;
      div_v[0]  = (tex_size_ff[15:0] == 16'd0) ? 16'd1 : tex_size_ff[15:0];
      div_v[1]  = div_v[0];
      div_v[2]  = (tex_size_ff[31:16] == 16'd0) ? 16'd1 : tex_size_ff[31:16];
      div_v[3]  = div_v[2];
   end

   // pass sequencing: restarts on any write
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (csr_we) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_STEPS)) begin
            busy_in = 1'b0;
         end
      end
   end

   // restoring divider, one quotient bit per cycle per lane
   always_comb begin
      shl = '0;
      for (int l = 0; l < 4; l++) begin
         num_in[l] = num_ff[l];
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         if (busy_ff && !csr_we) begin
            if (cnt_ff == '0) begin
               num_in[l] = edge_v[l];
               rem_in[l] = '0;
               quo_in[l] = '0;
            end else begin
               shl       = {rem_ff[l], num_ff[l][31]};
               num_in[l] = {num_ff[l][30:0], 1'b0};
               if (shl >= {1'b0, div_v[l]}) begin
                  rem_in[l] = 16'(shl - {1'b0, div_v[l]});
                  quo_in[l] = {quo_ff[l][30:0], 1'b1};
               end else begin
                  rem_in[l] = shl[15:0];
                  quo_in[l] = {quo_ff[l][30:0], 1'b0};
               end
            end
         end
      end
   end

   // local corners, one product per cycle; y terms carry the negation
   always_comb begin
      tidx = 2'(cnt_ff - 1'b1);
      case (tidx)
         2'd0:    term = $signed({1'b0, rect_left_ff})   - $signed({1'b0, pivot_x_ff});
         2'd1:    term = $signed({1'b0, rect_right_ff})  - $signed({1'b0, pivot_x_ff});
         2'd2:    term = $signed({1'b0, pivot_y_ff})     - $signed({1'b0, rect_top_ff});
         default: term = $signed({1'b0, pivot_y_ff})     - $signed({1'b0, rect_bottom_ff});
      endcase
      mprod_in = term * $signed({1'b0, upp_ff});
      midx_in  = tidx;
      mvld_in  = busy_ff && !csr_we && (cnt_ff != '0) && (cnt_ff <= DCNT_W'(4));
      for (int k = 0; k < 4; k++) begin
         loc_in[k] = loc_ff[k];
      end
      if (mvld_ff) begin
         loc_in[midx_ff] = sat32(WIDE_W'(mprod_ff >>> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_right_ff  <= ONE_Q;
         rect_bottom_ff <= ONE_Q;
         pivot_x_ff     <= HALF_Q;
         pivot_y_ff     <= HALF_Q;
         upp_ff         <= UPP_ONE;
         tex_size_ff    <= TEX_SIZE_RST;
         busy_ff        <= 1'b1;
         cnt_ff         <= '0;
         mvld_ff        <= 1'b0;
      end else begin
         rect_left_ff   <= rect_left_in;
         rect_top_ff    <= rect_top_in;
         rect_right_ff  <= rect_right_in;
         rect_bottom_ff <= rect_bottom_in;
         pivot_x_ff     <= pivot_x_in;
         pivot_y_ff     <= pivot_y_in;
         upp_ff         <= upp_in;
         tex_size_ff    <= tex_size_in;
         busy_ff        <= busy_in;
         cnt_ff         <= cnt_in;
         mvld_ff        <= mvld_in;
      end
   end

   always_ff @(posedge clock) begin
      mprod_ff <= mprod_in;
      midx_ff  <= midx_in;
      for (int l = 0; l < 4; l++) begin
         num_ff[l] <= num_in[l];
         rem_ff[l] <= rem_in[l];
         quo_ff[l] <= quo_in[l];
         loc_ff[l] <= loc_in[l];
      end
   end

   always_comb begin
      setup.busy   = busy_ff;
      setup.loc_xa = loc_ff[0];
      setup.loc_xb = loc_ff[1];
      setup.loc_ya = loc_ff[2];
      setup.loc_yb = loc_ff[3];
      setup.tex_ua = (|quo_ff[0][31:17]) ? TEX_MAX : quo_ff[0][16:0];
      setup.tex_ub = (|quo_ff[1][31:17]) ? TEX_MAX : quo_ff[1][16:0];
      setup.tex_va = (|quo_ff[2][31:17]) ? TEX_MAX : quo_ff[2][16:0];
      setup.tex_vb = (|quo_ff[3][31:17]) ? TEX_MAX : quo_ff[3][16:0];
   end

   `SQV_CHECK(a_pass_bound, !busy_ff || (cnt_ff <= DCNT_W'(DIV_STEPS)), "setup pass overran")

endmodule

// ===== hdl/sqv_front.sv =====
// request intake: unpacks beats, drops the unused mode, flags rotation
// feeds a small register queue toward the back end; uses sqv_pkg
module sqv_front
   import sqv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   setup_busy,
   output logic                   q_valid,
   output item_type               q_item,
   input  logic                   q_pop
);
`include "assert_macros.svh"

   item_type            queue_ff [QUEUE_DEPTH];
   item_type            entry;
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                accept, push, pop;

   always_comb begin
      entry.func        = func_type'(req_tuser[1:0]);
      entry.pos_x       = req_tdata[31:0];
      entry.pos_y       = req_tdata[63:32];
      entry.scale_x     = req_tdata[87:64];
      entry.scale_y     = req_tdata[111:88];
      entry.angle       = req_tdata[132:112];
      entry.dest_left   = req_tdata[164:133];
      entry.dest_top    = req_tdata[196:165];
      entry.dest_right  = req_tdata[228:197];
      entry.dest_bottom = req_tdata[260:229];
      entry.rot         = (entry.func == FUNC_ROT) && (entry.angle != '0);
   end

   assign req_tready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH)) && !setup_busy;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (entry.func != FUNC_NONE);
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   `SQV_CHECK(a_queue_bound, count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue count overflow")

endmodule

// ===== hdl/sqv_back.sv =====
// corner math: scale, angle reduction, cordic sine/cosine, rotation, offset
// one item at a time from the queue, hands a finished quad to the emitter; uses sqv_pkg
module sqv_back
   import sqv_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      q_pop,
   input  setup_type setup,
   input  logic      emit_free,
   output logic      emit_load,
   output quad_type  quad
);
`include "assert_macros.svh"

   be_state_type state_ff, state_in;
   item_type     item_ff, item_in;

   logic signed [ANG_W-1:0] ang_ff, ang_in;
   logic                    flip_ff, flip_in;
   logic signed [CRD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    phase_ff, phase_in;

   logic signed [MUL_W-1:0] mp_ff [8];
   logic signed [MUL_W-1:0] mp_in [8];
   logic [31:0]             sc_ff [4];
   logic [31:0]             sc_in [4];
   logic [31:0]             rx_ff [4];
   logic [31:0]             rx_in [4];
   logic [31:0]             ry_ff [4];
   logic [31:0]             ry_in [4];

   logic signed [31:0]      mul_a [4];
   logic signed [CRD_W-1:0] mul_b [4];
   logic signed [MUL_W-1:0] prod  [4];
   logic signed [CRD_W-1:0] cs, sn, sdx, sdy, scx, scy;
   logic signed [MUL_W:0]   rsum;
   logic signed [MUL_W-1:0] sh_mp;
   logic [31:0]             base_x, base_y;
   logic                    ix, iy;
   logic                    last_iter;

   assign last_iter = (iter_ff == ITER_W'(CORDIC_ROUNDS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BE_IDLE:    if (q_valid) state_in = BE_SCALE;
         BE_SCALE:   state_in = BE_POST;
         BE_POST:    state_in = item_ff.rot ? BE_REDUCE : BE_DONE;
         BE_REDUCE: begin
            if ((ang_ff <= PI_Q30) && (ang_ff >= -PI_Q30)) state_in = BE_CORDIC;
         end
         BE_CORDIC:  if (last_iter) state_in = BE_ROT;
         BE_ROT:     if (phase_ff) state_in = BE_ROTPOST;
         BE_ROTPOST: state_in = BE_DONE;
         BE_DONE:    if (emit_free) state_in = BE_IDLE;
         default:    state_in = BE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop     = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         BE_IDLE: q_pop     = q_valid;
         BE_DONE: emit_load = emit_free;
         default: ;
      endcase
   end

   // shared bank of four multipliers
   always_comb begin
      cs = flip_ff ? -cx_ff : cx_ff;
      sn = flip_ff ? -cy_ff : cy_ff;
      if (state_ff == BE_ROT) begin
         for (int k = 0; k < 4; k++) begin
            mul_a[k] = $signed(sc_ff[k]);
         end
         mul_b[0] = phase_ff ? sn : cs;
         mul_b[1] = phase_ff ? sn : cs;
         mul_b[2] = phase_ff ? cs : sn;
         mul_b[3] = phase_ff ? cs : sn;
      end else begin
         mul_a[0] = $signed(setup.loc_xa);
         mul_a[1] = $signed(setup.loc_xb);
         mul_a[2] = $signed(setup.loc_ya);
         mul_a[3] = $signed(setup.loc_yb);
         mul_b[0] = CRD_W'($signed(item_ff.scale_x));
         mul_b[1] = CRD_W'($signed(item_ff.scale_x));
         mul_b[2] = CRD_W'($signed(item_ff.scale_y));
         mul_b[3] = CRD_W'($signed(item_ff.scale_y));
      end
      for (int k = 0; k < 4; k++) begin
         prod[k] = mul_a[k] * mul_b[k];
      end
   end

   // datapath
   always_comb begin
      item_in  = item_ff;
      ang_in   = ang_ff;
      flip_in  = flip_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      iter_in  = iter_ff;
      phase_in = phase_ff;
      sdx      = cy_ff >>> iter_ff;
      sdy      = cx_ff >>> iter_ff;
      scx      = cx_ff;
      scy      = cy_ff;
      rsum     = '0;
      sh_mp    = '0;
      ix       = 1'b0;
      iy       = 1'b0;
      for (int k = 0; k < 8; k++) begin
         mp_in[k] = mp_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         sc_in[k] = sc_ff[k];
         rx_in[k] = rx_ff[k];
         ry_in[k] = ry_ff[k];
      end
      case (state_ff)
         BE_IDLE: begin
            if (q_valid) item_in = q_item;
            phase_in = 1'b0;
         end
         BE_SCALE: begin
            for (int k = 0; k < 4; k++) begin
               mp_in[k] = prod[k];
            end
         end
         BE_POST: begin
            for (int k = 0; k < 4; k++) begin
               sh_mp    = mp_ff[k] >>> FRAC_BITS;
               sc_in[k] = sat32(WIDE_W'(sh_mp));
            end
            ang_in  = ANG_W'($signed(item_ff.angle)) <<< (CORDIC_FRAC - FRAC_BITS);
            flip_in = 1'b0;
         end
         BE_REDUCE: begin
            // wrap into one turn, then fold into the right half plane
            if (ang_ff > PI_Q30) begin
               ang_in = ang_ff - TWO_PI_Q30;
            end else if (ang_ff < -PI_Q30) begin
               ang_in = ang_ff + TWO_PI_Q30;
            end else begin
               if (ang_ff > HALF_PI_Q30) begin
                  ang_in  = ang_ff - PI_Q30;
                  flip_in = 1'b1;
               end else if (ang_ff < -HALF_PI_Q30) begin
                  ang_in  = ang_ff + PI_Q30;
                  flip_in = 1'b1;
               end
               cx_in   = CORDIC_GAIN;
               cy_in   = '0;
               iter_in = '0;
            end
         end
         BE_CORDIC: begin
            if (ang_ff >= 0) begin
               scx    = cx_ff - sdx;
               scy    = cy_ff + sdy;
               ang_in = ang_ff - atan_q30(iter_ff);
            end else begin
               scx    = cx_ff + sdx;
               scy    = cy_ff - sdy;
               ang_in = ang_ff + atan_q30(iter_ff);
            end
            cx_in   = scx;
            cy_in   = scy;
            iter_in = iter_ff + 1'b1;
         end
         BE_ROT: begin
            for (int k = 0; k < 4; k++) begin
               if (phase_ff) mp_in[4 + k] = prod[k];
               else          mp_in[k]     = prod[k];
            end
            phase_in = !phase_ff;
         end
         BE_ROTPOST: begin
            // products: 0-1 x*cos, 2-3 y*sin, 4-5 x*sin, 6-7 y*cos
            for (int k = 0; k < 4; k++) begin
               ix       = (k == 1) || (k == 2);
               iy       = (k >= 2);
               rsum     = (MUL_W + 1)'(mp_ff[{2'b00, ix}]) - (MUL_W + 1)'(mp_ff[{2'b01, iy}]);
               rx_in[k] = sat32(WIDE_W'(rsum >>> CORDIC_FRAC));
               rsum     = (MUL_W + 1)'(mp_ff[{2'b10, ix}]) + (MUL_W + 1)'(mp_ff[{2'b11, iy}]);
               ry_in[k] = sat32(WIDE_W'(rsum >>> CORDIC_FRAC));
            end
         end
         default: ;
      endcase
   end

   // finished quad: destination rectangle as given, else offset by position
   always_comb begin
      base_x = '0;
      base_y = '0;
      for (int k = 0; k < 4; k++) begin
         if (item_ff.rot) begin
            base_x = rx_ff[k];
            base_y = ry_ff[k];
         end else begin
            base_x = ((k == 1) || (k == 2)) ? sc_ff[1] : sc_ff[0];
            base_y = (k >= 2) ? sc_ff[3] : sc_ff[2];
         end
         if (item_ff.func == FUNC_DEST) begin
            quad.vx[k] = ((k == 1) || (k == 2)) ? item_ff.dest_right : item_ff.dest_left;
            quad.vy[k] = (k >= 2) ? item_ff.dest_bottom : item_ff.dest_top;
         end else begin
            quad.vx[k] = sat32(WIDE_W'($signed(base_x)) + WIDE_W'($signed(item_ff.pos_x)));
            quad.vy[k] = sat32(WIDE_W'($signed(base_y)) + WIDE_W'($signed(item_ff.pos_y)));
         end
      end
      quad.ua = setup.tex_ua;
      quad.ub = setup.tex_ub;
      quad.va = setup.tex_va;
      quad.vb = setup.tex_vb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      ang_ff   <= ang_in;
      flip_ff  <= flip_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      iter_ff  <= iter_in;
      phase_ff <= phase_in;
      for (int k = 0; k < 8; k++) begin
         mp_ff[k] <= mp_in[k];
      end
      for (int k = 0; k < 4; k++) begin
         sc_ff[k] <= sc_in[k];
         rx_ff[k] <= rx_in[k];
         ry_ff[k] <= ry_in[k];
      end
   end

   `SQV_CHECK_NEXT(a_cordic_exit, (state_ff == BE_CORDIC) && last_iter, state_ff == BE_ROT, "cordic did not finish after last round")
   `SQV_CHECK(a_rot_only, (state_ff != BE_CORDIC) || item_ff.rot, "cordic running for item without rotation")

endmodule

// ===== hdl/sqv_emit.sv =====
// result side: holds one finished quad and sends its four corners as beats
// output register between the back end and the result channel; uses sqv_pkg
module sqv_emit
   import sqv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  quad_type               quad,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);
`include "assert_macros.svh"

   quad_type   bank_ff, bank_in;
   logic       busy_ff, busy_in;
   logic [1:0] corner_ff, corner_in;
   logic       done_beat;
   logic [16:0] u_sel, v_sel;

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (corner_ff == 2'd3);
   assign done_beat  = rsp_tvalid && rsp_tready && rsp_tlast;
   assign free       = !busy_ff || done_beat;

   always_comb begin
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      corner_in = corner_ff;
      if (rsp_tvalid && rsp_tready) begin
         corner_in = corner_ff + 1'b1;
         if (rsp_tlast) busy_in = 1'b0;
      end
      if (load) begin
         bank_in   = quad;
         busy_in   = 1'b1;
         corner_in = 2'd0;
      end
   end

   always_comb begin
      u_sel     = ((corner_ff == 2'd1) || (corner_ff == 2'd2)) ? bank_ff.ub : bank_ff.ua;
      v_sel     = corner_ff[1] ? bank_ff.vb : bank_ff.va;
      rsp_tdata = {4'd0, v_sel, u_sel, bank_ff.vy[corner_ff], bank_ff.vx[corner_ff], corner_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
   end

   `SQV_CHECK(a_load_when_free, !load || free, "quad loaded over one still being sent")

endmodule

// ===== hdl/sprite_quad_vertex_gen.sv =====
// top level of the sprite quad corner generator
// instantiates sqv_setup, sqv_front, sqv_back and sqv_emit; uses sqv_pkg
//
//   channel   direction  beat contents
//   req_      in         tuser: func; tdata: pos, scale, angle, dest rectangle
//   rsp_      out        tdata: corner, vert_x, vert_y, tex_u, tex_v; tlast on corner 3
//   csr_      in         write enable, register index, 32-bit data
//
// each request gives four beats; func 3 is dropped at intake and gives none
// position/scale and destination-rectangle requests are paced by the
//   four-beat output; a rotated request is paced by the 30-round
//   single-step cordic and up to three angle wraps before it
// reset is synchronous; after reset and after every csr write a setup pass
//   (texture dividers, local corner products) holds req_tready low
// a two-entry queue and the output register let intake, math and output stall apart
module sprite_quad_vertex_gen
   import sqv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x, pos_y, scale_x, scale_y, angle, dest_left, dest_top, dest_right,
   // dest_bottom, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // corner, vert_x, vert_y, tex_u, tex_v, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   setup_type setup;
   item_type  q_item;
   quad_type  quad;
   logic      q_valid, q_pop, emit_free, emit_load;

   // config registers and values derived from them
   sqv_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .setup     (setup)
   );

   // intake and classification
   sqv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .setup_busy (setup.busy),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // corner math
   sqv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .setup     (setup),
      .emit_free (emit_free),
      .emit_load (emit_load),
      .quad      (quad)
   );

   // four beats per quad
   sqv_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .quad       (quad),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/tb.sv =====
// testbench for sprite_quad_vertex_gen: directed and random draw requests
// checked against a quad-corner predictor held in a small scoreboard class
// depends on hdl/sqv_pkg.sv and the generator rtl
`timescale 1ns / 100ps

module tb;
   import sqv_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = CSR_ADDR_W'(15);

   typedef struct {
      bit signed [31:0] pos_x, pos_y;
      bit signed [23:0] scale_x, scale_y;
      bit signed [20:0] angle;
      bit signed [31:0] dest_left, dest_top, dest_right, dest_bottom;
   } draw_type;

   typedef struct {
      bit [1:0]  corner;
      bit [31:0] vx, vy;
      bit [16:0] u, v;
      bit        last;
   } corner_type;

   // predicts the four corners of each draw and checks them in order
   class quad_scoreboard;
      bit [31:0]  regs[8];
      corner_type corners_due[$];
      int         errors;
      longint     atan_tbl[30] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
         65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
         16, 8, 4, 2};

      function void reset_regs();
         regs = '{32'd0, 32'd0, ONE_Q, ONE_Q, HALF_Q, HALF_Q, 32'(UPP_ONE), TEX_SIZE_RST};
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, bit [31:0] val);
         if (idx == CSR_UPP) regs[idx] = val & 32'h00FF_FFFF;
         else if (idx <= CSR_TEX_SIZE) regs[idx] = val;
      endfunction

      function longint clamp_s32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function bit [16:0] tex_norm(bit [31:0] edge_q, bit [15:0] size);
         longint q;
         q = longint'(edge_q) / ((size == 0) ? 1 : longint'(size));
         return (q > 'h1FFFF) ? 17'h1FFFF : q[16:0];
      endfunction

      // cordic sine/cosine in q2.30
      function void sincos(bit signed [20:0] ang, output longint sn, output longint cs);
         longint a, x, y, t, dx, dy;
         bit     flip;
         a = longint'(ang) * 16384;
         x = 652032874;
         y = 0;
         flip = 0;
         while (a > 64'sd3373259426) a -= 64'sd6746518852;
         while (a < -64'sd3373259426) a += 64'sd6746518852;
         if (a > 64'sd1686629713) begin
            a -= 64'sd3373259426; flip = 1;
         end else if (a < -64'sd1686629713) begin
            a += 64'sd3373259426; flip = 1;
         end
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0) begin
               t = x - dx; y = y + dy; a -= atan_tbl[i];
            end else begin
               t = x + dx; y = y - dy; a += atan_tbl[i];
            end
            x = t;
         end
         cs = flip ? -x : x;
         sn = flip ? -y : y;
      endfunction

      function void note_draw(func_type fn, draw_type d);
         longint     xs[2], ys[2], upp, sn, cs, x, y, tx;
         bit [16:0]  us[2], vs[2];
         bit         rot;
         corner_type c;
         if (fn == FUNC_NONE) return;
         sn = 0; cs = 0;
         rot = (fn == FUNC_ROT) && (d.angle != 0);
         us[0] = tex_norm(regs[CSR_RECT_LEFT], regs[CSR_TEX_SIZE][15:0]);
         us[1] = tex_norm(regs[CSR_RECT_RIGHT], regs[CSR_TEX_SIZE][15:0]);
         vs[0] = tex_norm(regs[CSR_RECT_TOP], regs[CSR_TEX_SIZE][31:16]);
         vs[1] = tex_norm(regs[CSR_RECT_BOTTOM], regs[CSR_TEX_SIZE][31:16]);
         if (fn == FUNC_DEST) begin
            xs[0] = d.dest_left;  ys[0] = d.dest_top;
            xs[1] = d.dest_right; ys[1] = d.dest_bottom;
         end else begin
            upp = longint'(regs[CSR_UPP]);
            xs[0] = clamp_s32(((longint'(regs[CSR_RECT_LEFT]) -
                                longint'(regs[CSR_PIVOT_X])) * upp) >>> FRAC_BITS);
            xs[1] = clamp_s32(((longint'(regs[CSR_RECT_RIGHT]) -
                                longint'(regs[CSR_PIVOT_X])) * upp) >>> FRAC_BITS);
            ys[0] = clamp_s32((-((longint'(regs[CSR_RECT_TOP]) -
                                  longint'(regs[CSR_PIVOT_Y])) * upp)) >>> FRAC_BITS);
            ys[1] = clamp_s32((-((longint'(regs[CSR_RECT_BOTTOM]) -
                                  longint'(regs[CSR_PIVOT_Y])) * upp)) >>> FRAC_BITS);
            for (int k = 0; k < 2; k++) begin
               xs[k] = clamp_s32((xs[k] * longint'(d.scale_x)) >>> FRAC_BITS);
               ys[k] = clamp_s32((ys[k] * longint'(d.scale_y)) >>> FRAC_BITS);
            end
            if (rot) sincos(d.angle, sn, cs);
         end
         for (int k = 0; k < 4; k++) begin
            x = xs[(k == 1 || k == 2)];
            y = ys[k >= 2];
            if (fn != FUNC_DEST) begin
               if (rot) begin
                  tx = clamp_s32((x * cs - y * sn) >>> 30);
                  y  = clamp_s32((x * sn + y * cs) >>> 30);
                  x  = tx;
               end
               x = clamp_s32(x + longint'(d.pos_x));
               y = clamp_s32(y + longint'(d.pos_y));
            end
            c.corner = k[1:0];
            c.vx = x[31:0];
            c.vy = y[31:0];
            c.u = us[(k == 1 || k == 2)];
            c.v = vs[k >= 2];
            c.last = (k == 3);
            corners_due.push_back(c);
         end
      endfunction

      function void check_corner(corner_type got);
         corner_type want;
         if (corners_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected corner beat %0d", got.corner);
            return;
         end
         want = corners_due.pop_front();
         if (got != want) begin
            errors++;
            if (errors <= 10)
               $display({"corner mismatch exp c%0d x=%h y=%h u=%h v=%h l=%b",
                         " got c%0d x=%h y=%h u=%h v=%h l=%b"},
                        want.corner, want.vx, want.vy, want.u, want.v, want.last,
                        got.corner, got.vx, got.vy, got.u, got.v, got.last);
         end
      endfunction
   endclass

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   quad_scoreboard sb = new();
   int  send_idle_pct = 0;   // percent of cycles the sender sits out
   int  recv_idle_pct = 0;   // percent of cycles the receiver stalls
   bit  hold_request = 0;    // asks the receiver for a long hold-off
   int  hold_left = 0;
   longint cycles = 0;

   sprite_quad_vertex_gen dut (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stalls, plus a long counted hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 0;
      end else if (hold_left > 0) begin
         rsp_tready = 0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = HOLD_CYCLES;
         rsp_tready = 0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // output monitor: unpack corner beat, lowest field first
   always @(posedge clock) begin
      corner_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.corner = rsp_tdata[1:0];
         got.vx = rsp_tdata[33:2];
         got.vy = rsp_tdata[65:34];
         got.u = rsp_tdata[82:66];
         got.v = rsp_tdata[99:83];
         got.last = rsp_tlast;
         sb.check_corner(got);
      end
   end

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, bit [31:0] val);
      @(negedge clock);
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, val);
   endtask

   // block idle: no corners owed, then a margin for dropped func 3 draws
   task automatic wait_idle();
      while (sb.corners_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offers one draw; returns after the beat is taken
   task automatic send_draw(func_type fn, draw_type d);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = fn;
      req_tdata = {3'b0, d.dest_bottom, d.dest_right, d.dest_top, d.dest_left,
                   d.angle, d.scale_y, d.scale_x, d.pos_y, d.pos_x};
      do @(posedge clock); while (!req_tready);
      sb.note_draw(fn, d);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // 32-bit value leaning on the extremes and zero
   function automatic bit [31:0] edgy32();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   function automatic draw_type random_draw();
      draw_type d;
      bit       wild;
      wild = ($urandom_range(3) == 0);
      d.pos_x = wild ? edgy32() : $signed($urandom_range(2000000)) - 1000000;
      d.pos_y = wild ? edgy32() : $signed($urandom_range(2000000)) - 1000000;
      d.scale_x = wild ? 24'($urandom) : 24'($signed($urandom_range(524288)) - 262144);
      d.scale_y = wild ? 24'($urandom) : 24'($signed($urandom_range(524288)) - 262144);
      d.angle = ($urandom_range(9) == 0) ? 21'd0 : 21'($urandom);
      d.dest_left = edgy32();
      d.dest_top = edgy32();
      d.dest_right = edgy32();
      d.dest_bottom = edgy32();
      return d;
   endfunction

   function automatic func_type random_func();
      return ($urandom_range(19) == 0) ? FUNC_NONE : func_type'($urandom_range(2));
   endfunction

   task automatic random_config(int flavor);
      case (flavor)
         0: begin   // rect, upp and texture size at their top, pivot at zero
            write_csr(CSR_RECT_LEFT, 32'hFFFF_FFFF);
            write_csr(CSR_RECT_TOP, 32'hFFFF_FFFF);
            write_csr(CSR_RECT_RIGHT, 32'hFFFF_FFFF);
            write_csr(CSR_RECT_BOTTOM, 32'hFFFF_FFFF);
            write_csr(CSR_PIVOT_X, 32'h0);
            write_csr(CSR_PIVOT_Y, 32'h0);
            write_csr(CSR_UPP, 32'h00FF_FFFF);
            write_csr(CSR_TEX_SIZE, 32'hFFFF_FFFF);
         end
         1: begin   // zero texture dimensions, pivot beyond the rect
            write_csr(CSR_RECT_LEFT, 32'h0);
            write_csr(CSR_RECT_TOP, 32'h0);
            write_csr(CSR_RECT_RIGHT, 32'h0001_8000);
            write_csr(CSR_RECT_BOTTOM, 32'h0);
            write_csr(CSR_PIVOT_X, 32'hFFFF_FFFF);
            write_csr(CSR_PIVOT_Y, 32'hFFFF_FFFF);
            write_csr(CSR_UPP, 32'h0);
            write_csr(CSR_TEX_SIZE, 32'h0);
         end
         default: begin   // plausible sprite sheet cell
            write_csr(CSR_RECT_LEFT, $urandom_range(64) << 16);
            write_csr(CSR_RECT_TOP, $urandom_range(64) << 16);
            write_csr(CSR_RECT_RIGHT, $urandom_range(128, 64) << 16);
            write_csr(CSR_RECT_BOTTOM, $urandom_range(128, 64) << 16);
            write_csr(CSR_PIVOT_X, $urandom_range(8388608));
            write_csr(CSR_PIVOT_Y, $urandom_range(8388608));
            write_csr(CSR_UPP, $urandom_range(262144));
            write_csr(CSR_TEX_SIZE, ($urandom_range(512, 1) << 16) | $urandom_range(512, 1));
         end
      endcase
      // write to an index past the register file, must be ignored
      write_csr(CSR_UNUSED, $urandom);
   endtask

   initial begin
      draw_type d;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      sb.reset_regs();

      // directed draws on reset config
      d = '{default: 0};
      d.scale_x = 24'sh010000; d.scale_y = 24'sh010000;
      send_draw(FUNC_POS, d);
      d.pos_x = 32'sh7FFF_FFFF; d.pos_y = 32'sh8000_0000;
      d.scale_x = 24'sh7FFFFF; d.scale_y = 24'sh800000;
      send_draw(FUNC_POS, d);
      d.pos_x = 32'sh8000_0000; d.pos_y = 32'sh7FFF_FFFF;
      d.scale_x = 24'sh800000; d.scale_y = 24'sh7FFFFF;
      send_draw(FUNC_POS, d);
      d.angle = 21'sd0;
      send_draw(FUNC_ROT, d);             // zero angle rotates nothing
      d.pos_x = 0; d.pos_y = 0;
      d.scale_x = 24'sh020000; d.scale_y = 24'sh020000;
      d.angle = 21'sh0FFFFF;
      send_draw(FUNC_ROT, d);
      d.angle = 21'sh100000;
      send_draw(FUNC_ROT, d);
      d.angle = 21'sd102944;              // about pi/2
      send_draw(FUNC_ROT, d);
      d.angle = -21'sd205887;             // about -pi
      send_draw(FUNC_ROT, d);
      send_draw(FUNC_NONE, d);            // dropped, no corners
      d.dest_left = 32'sh8000_0000; d.dest_top = 32'sh7FFF_FFFF;
      d.dest_right = 32'sh7FFF_FFFF; d.dest_bottom = 32'sh8000_0000;
      send_draw(FUNC_DEST, d);
      d.dest_left = 0; d.dest_top = -1; d.dest_right = 1; d.dest_bottom = 0;
      send_draw(FUNC_DEST, d);
      end_burst();
      wait_idle();

      // random part: six chunks, each with its own config, each pair with its own stall mix
      for (int chunk = 0; chunk < 6; chunk++) begin
         random_config(chunk < 2 ? chunk : 2);
         case (chunk / 2)
            0: begin send_idle_pct = 19; recv_idle_pct = 83; end
            1: begin send_idle_pct = 83; recv_idle_pct = 19; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (chunk == 4) hold_request = 1;   // output blocked, input must back up
         for (int n = 0; n < 20; n++)
            send_draw(random_func(), random_draw());
         end_burst();
         wait_idle();
      end

      if (sb.errors == 0 && sb.corners_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
